@@ sv/assert_macros.svh @@
// assertion macros for the rtl file that checks itself
// depends on nothing; each macro takes the clock and the active-low reset

`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, masked while reset is asserted
`define ASSERT_IMPLIES(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("implication check failed");

// next-cycle implication, masked while reset is asserted
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("next-cycle check failed");

`endif

@@ sv/bdel_pkg.sv @@
// shared types and constants of the bounded double-ended list unit
// used by bdel_cell and bounded_double_ended_list_unit; depends on nothing

package bdel_pkg;

  // default sizes
  localparam int CAPACITY_DEF   = 16;
  localparam int DATA_WIDTH_DEF = 32;

  // fixed widths of the port fields
  localparam int OPCODE_W    = 3;
  localparam int PORT_DATA_W = 32;
  localparam int POS_W       = 4;
  localparam int STATUS_W    = 2;
  localparam int ENTRY_CNT_W = 5;

  typedef enum logic [OPCODE_W-1:0] {
    OP_PUSH_FRONT = 3'd0,
    OP_PUSH_BACK  = 3'd1,
    OP_POP_FRONT  = 3'd2,
    OP_POP_BACK   = 3'd3,
    OP_READ       = 3'd4
  } op_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK        = 2'd0,
    ST_EMPTY     = 2'd1,
    ST_FULL      = 2'd2,
    ST_OUT_RANGE = 2'd3
  } status_t;

  // per-cycle command broadcast to every cell of the row
  typedef struct packed {
    logic shift_right;  // push front: every element moves one cell back
    logic shift_left;   // pop front: every element moves one cell forward
    logic append;       // push back: the cell at the current count loads
  } cell_ctl_t;

endpackage

@@ sv/bdel_cell.sv @@
// one storage cell of the element row; holds the element at its position
// depends on bdel_pkg for the command struct

module bdel_cell #(
  parameter int DATA_WIDTH = bdel_pkg::DATA_WIDTH_DEF,
  parameter int CNT_W      = 5,
  parameter int IDX        = 0
) (
  input  logic                  clk,
  input  bdel_pkg::cell_ctl_t   ctl,
  input  logic [CNT_W-1:0]      count,
  input  logic [DATA_WIDTH-1:0] from_prev,
  input  logic [DATA_WIDTH-1:0] from_next,
  input  logic [DATA_WIDTH-1:0] din,
  output logic [DATA_WIDTH-1:0] val
);

  logic [DATA_WIDTH-1:0] val_r;
  logic [DATA_WIDTH-1:0] val_nxt;

  always_comb begin
    val_nxt = val_r;
    if (ctl.shift_right) begin
      val_nxt = from_prev;
    end else if (ctl.shift_left) begin
      val_nxt = from_next;
    end else if (ctl.append && (count == CNT_W'(IDX))) begin
      val_nxt = din;
    end
  end

  // payload only, no reset
  always_ff @(posedge clk) begin
    val_r <= val_nxt;
  end

  assign val = val_r;

endmodule

@@ sv/bounded_double_ended_list_unit.sv @@
// top level of the bounded double-ended list unit: control, cell row, result register
// depends on bdel_pkg, bdel_cell and assert_macros.svh

// Bounded double-ended list (deque) held as a row of CAPACITY cells, cell 0 holding the
// front element. Each input beat is one operation: push front, push back, pop front,
// pop back or read at a position. A push front shifts the whole row one cell back and
// loads cell 0; a pop front shifts it one cell forward; a push back loads the cell at
// the current count; pops and reads take one cell through a single read mux. Every
// beat returns exactly one result beat with the popped or read value (0 on pushes and
// errors), a status (ok, pop on empty, push dropped when full, position out of range),
// the count after the operation (modulo 32) and an empty flag. Unused opcodes leave the
// list alone and report ok. Throughput is one beat per clock while results are taken;
// the result appears in the output register in the cycle after acceptance, fed by the
// read mux in front of the result register. A new beat is taken while a result waits,
// as long as the consumer takes that result in the same cycle. Stored values are not
// cleared by reset; only positions below the count are ever returned.

`include "assert_macros.svh"

module bounded_double_ended_list_unit #(
  parameter int CAPACITY   = bdel_pkg::CAPACITY_DEF,
  parameter int DATA_WIDTH = bdel_pkg::DATA_WIDTH_DEF
) (
  input  logic                               clk,
  input  logic                               rst_n,
  // input channel
  input  logic                               in_valid,
  output logic                               in_ready,
  input  logic [bdel_pkg::OPCODE_W-1:0]      in_opcode,
  input  logic [bdel_pkg::PORT_DATA_W-1:0]   in_data_in,
  input  logic [bdel_pkg::POS_W-1:0]         in_position,
  // result channel
  output logic                               out_valid,
  input  logic                               out_ready,
  output logic [bdel_pkg::PORT_DATA_W-1:0]   out_data_out,
  output logic [bdel_pkg::STATUS_W-1:0]      out_status,
  output logic [bdel_pkg::ENTRY_CNT_W-1:0]   out_entry_count,
  output logic                               out_is_empty
);

  localparam int CNT_W = $clog2(CAPACITY + 1);
  localparam int IDX_W = $clog2(CAPACITY);
  // common width for comparing a position against the count
  localparam int CMP_W = (CNT_W > bdel_pkg::POS_W) ? CNT_W : bdel_pkg::POS_W;

  // list control state
  logic [CNT_W-1:0] count_r;
  logic [CNT_W-1:0] count_nxt;

  // result register
  logic                                  out_valid_r;
  logic [bdel_pkg::PORT_DATA_W-1:0]      data_out_r;
  logic [bdel_pkg::STATUS_W-1:0]         status_r;
  logic [bdel_pkg::ENTRY_CNT_W-1:0]      entry_count_r;
  logic                                  is_empty_r;

  logic                  in_fire;
  logic                  is_full;
  logic                  is_empty_now;
  logic [DATA_WIDTH-1:0] din;
  logic [IDX_W-1:0]      rd_idx;
  logic                  rd_en;
  logic [DATA_WIDTH-1:0] rd_data;
  bdel_pkg::status_t     status_nxt;
  bdel_pkg::cell_ctl_t   ctl;
  bdel_pkg::cell_ctl_t   ctl_fire;

  // cell outputs, each read by its neighbors and by the read mux
  logic [DATA_WIDTH-1:0] cell_q [CAPACITY];

  // a new beat goes in when the result slot is free or being drained
  assign in_ready = !out_valid_r || out_ready;
  assign in_fire  = in_valid && in_ready;

  assign is_full      = (count_r == CNT_W'(CAPACITY));
  assign is_empty_now = (count_r == '0);
  assign din          = DATA_WIDTH'(in_data_in);

  // decode the operation against the current count
  always_comb begin
    count_nxt  = count_r;
    status_nxt = bdel_pkg::ST_OK;
    ctl        = '0;
    rd_en      = 1'b0;
    rd_idx     = '0;
    case (in_opcode)
      bdel_pkg::OP_PUSH_FRONT: begin
        if (is_full) begin
          status_nxt = bdel_pkg::ST_FULL;
        end else begin
          ctl.shift_right = 1'b1;
          count_nxt       = count_r + CNT_W'(1);
        end
      end
      bdel_pkg::OP_PUSH_BACK: begin
        if (is_full) begin
          status_nxt = bdel_pkg::ST_FULL;
        end else begin
          ctl.append = 1'b1;
          count_nxt  = count_r + CNT_W'(1);
        end
      end
      bdel_pkg::OP_POP_FRONT: begin
        if (is_empty_now) begin
          status_nxt = bdel_pkg::ST_EMPTY;
        end else begin
          // front element sits in cell 0
          rd_en          = 1'b1;
          ctl.shift_left = 1'b1;
          count_nxt      = count_r - CNT_W'(1);
        end
      end
      bdel_pkg::OP_POP_BACK: begin
        if (is_empty_now) begin
          status_nxt = bdel_pkg::ST_EMPTY;
        end else begin
          rd_en     = 1'b1;
          rd_idx    = IDX_W'(count_r - CNT_W'(1));
          count_nxt = count_r - CNT_W'(1);
        end
      end
      bdel_pkg::OP_READ: begin
        if (CMP_W'(in_position) >= CMP_W'(count_r)) begin
          status_nxt = bdel_pkg::ST_OUT_RANGE;
        end else begin
          rd_en  = 1'b1;
          rd_idx = IDX_W'(in_position);
        end
      end
      default: begin
        // unused opcode: nothing changes
      end
    endcase
  end

  // single read port over the cell row
  assign rd_data = rd_en ? cell_q[rd_idx] : '0;

  // the row only moves on an accepted beat
  assign ctl_fire = in_fire ? ctl : '0;

  // row of cells, cell 0 at the front
  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    logic [DATA_WIDTH-1:0] from_prev;
    logic [DATA_WIDTH-1:0] from_next;

    if (i == 0) begin : g_head
      assign from_prev = din;
    end else begin : g_body
      assign from_prev = cell_q[i-1];
    end

    if (i == CAPACITY - 1) begin : g_tail
      assign from_next = cell_q[i];
    end else begin : g_inner
      assign from_next = cell_q[i+1];
    end

    bdel_cell #(
      .DATA_WIDTH (DATA_WIDTH),
      .CNT_W      (CNT_W),
      .IDX        (i)
    ) u_cell (
      .clk       (clk),
      .ctl       (ctl_fire),
      .count     (count_r),
      .from_prev (from_prev),
      .from_next (from_next),
      .din       (din),
      .val       (cell_q[i])
    );
  end

  // control state and the result valid flag
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (in_fire) begin
        count_r <= count_nxt;
      end
      if (in_fire) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // result payload, loaded with the beat that produced it
  always_ff @(posedge clk) begin
    if (in_fire) begin
      data_out_r    <= bdel_pkg::PORT_DATA_W'(rd_data);
      status_r      <= status_nxt;
      entry_count_r <= bdel_pkg::ENTRY_CNT_W'(count_nxt);
      is_empty_r    <= (count_nxt == '0);
    end
  end

  assign out_valid       = out_valid_r;
  assign out_data_out    = data_out_r;
  assign out_status      = status_r;
  assign out_entry_count = entry_count_r;
  assign out_is_empty    = is_empty_r;

  // checks
  `ASSERT_IMPLIES(a_count_bound, clk, rst_n, 1'b1, count_r <= CNT_W'(CAPACITY))
  `ASSERT_NEXT(a_error_keeps_count, clk, rst_n, in_fire && (status_nxt != bdel_pkg::ST_OK), $stable(count_r))
  `ASSERT_NEXT(a_push_grows, clk, rst_n, in_fire && (ctl.shift_right || ctl.append), count_r == $past(count_r) + CNT_W'(1))
  `ASSERT_IMPLIES(a_empty_means_zero, clk, rst_n, out_valid_r && is_empty_r, entry_count_r == '0)

endmodule

@@ tb/bounded_double_ended_list_unit_tb.sv @@
`timescale 1ns / 100ps
// self-checking testbench of the bounded double-ended list unit: directed table, random beats
// depends on bdel_pkg and bounded_double_ended_list_unit; checked against a ring predictor

module bounded_double_ended_list_unit_tb;

  // opcodes that the unit treats as no operation
  localparam logic [bdel_pkg::OPCODE_W-1:0] OP_SPARE_5 = 3'd5;
  localparam logic [bdel_pkg::OPCODE_W-1:0] OP_SPARE_6 = 3'd6;
  localparam logic [bdel_pkg::OPCODE_W-1:0] OP_SPARE_7 = 3'd7;

  localparam int CAP          = bdel_pkg::CAPACITY_DEF;
  localparam int RANDOM_BEATS = 600;
  localparam int CYCLE_LIMIT  = 200000;
  localparam int IDLE_PCT     = 28;

  // one result beat as the unit reports it
  typedef struct packed {
    logic [bdel_pkg::PORT_DATA_W-1:0] data_out;
    bdel_pkg::status_t                status;
    logic [bdel_pkg::ENTRY_CNT_W-1:0] count;
    logic                             empty;
  } result_t;

  // one row of the directed table; typed rows carry a hand-written expectation
  typedef struct {
    logic [bdel_pkg::OPCODE_W-1:0]    op;
    logic [bdel_pkg::PORT_DATA_W-1:0] word;
    logic [bdel_pkg::POS_W-1:0]       pos;
    bit                               typed;
    result_t                          want;
  } stim_row_t;

  logic                             clk;
  logic                             rst_n       = 1'b0;
  logic                             in_valid    = 1'b0;
  logic                             in_ready;
  logic [bdel_pkg::OPCODE_W-1:0]    in_opcode   = '0;
  logic [bdel_pkg::PORT_DATA_W-1:0] in_data_in  = '0;
  logic [bdel_pkg::POS_W-1:0]       in_position = '0;
  logic                             out_valid;
  logic                             out_ready   = 1'b0;
  logic [bdel_pkg::PORT_DATA_W-1:0] out_data_out;
  logic [bdel_pkg::STATUS_W-1:0]    out_status;
  logic [bdel_pkg::ENTRY_CNT_W-1:0] out_entry_count;
  logic                             out_is_empty;

  // predictor state: a ring of CAP words, the slot of the front and the element count
  logic [bdel_pkg::PORT_DATA_W-1:0] list_words [CAP];
  logic [bdel_pkg::POS_W-1:0]       front_slot = '0;
  logic [bdel_pkg::ENTRY_CNT_W-1:0] list_count = '0;

  result_t   pending_results [$];
  stim_row_t directed_rows [$];
  int        mismatches = 0;
  int        cycles     = 0;
  int        beats_seen = 0;
  bit        calm       = 1'b0;  // set during the stretch with no idling on either side

  bounded_double_ended_list_unit i_dut (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .in_opcode       (in_opcode),
    .in_data_in      (in_data_in),
    .in_position     (in_position),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_data_out    (out_data_out),
    .out_status      (out_status),
    .out_entry_count (out_entry_count),
    .out_is_empty    (out_is_empty)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // applies one operation to the ring and returns the result beat it produces;
  // slot arithmetic wraps by itself since the ring has exactly 2**POS_W slots
  function automatic result_t apply_list_op(logic [bdel_pkg::OPCODE_W-1:0] op,
                                            logic [bdel_pkg::PORT_DATA_W-1:0] word,
                                            logic [bdel_pkg::POS_W-1:0] pos);
    result_t                    r;
    logic [bdel_pkg::POS_W-1:0] slot;
    r.data_out = '0;
    r.status   = bdel_pkg::ST_OK;
    case (op)
      bdel_pkg::OP_PUSH_FRONT: begin
        if (list_count == CAP) begin
          r.status = bdel_pkg::ST_FULL;
        end else begin
          front_slot = front_slot - 1'b1;
          list_words[front_slot] = word;
          list_count = list_count + 1'b1;
        end
      end
      bdel_pkg::OP_PUSH_BACK: begin
        if (list_count == CAP) begin
          r.status = bdel_pkg::ST_FULL;
        end else begin
          slot = front_slot + list_count[bdel_pkg::POS_W-1:0];
          list_words[slot] = word;
          list_count = list_count + 1'b1;
        end
      end
      bdel_pkg::OP_POP_FRONT: begin
        if (list_count == 0) begin
          r.status = bdel_pkg::ST_EMPTY;
        end else begin
          r.data_out = list_words[front_slot];
          front_slot = front_slot + 1'b1;
          list_count = list_count - 1'b1;
        end
      end
      bdel_pkg::OP_POP_BACK: begin
        if (list_count == 0) begin
          r.status = bdel_pkg::ST_EMPTY;
        end else begin
          // a full ring has count bits 3:0 at zero, so minus one lands on the last slot
          slot = front_slot + list_count[bdel_pkg::POS_W-1:0] - 1'b1;
          r.data_out = list_words[slot];
          list_count = list_count - 1'b1;
        end
      end
      bdel_pkg::OP_READ: begin
        if ({1'b0, pos} >= list_count) begin
          r.status = bdel_pkg::ST_OUT_RANGE;
        end else begin
          slot = front_slot + pos;
          r.data_out = list_words[slot];
        end
      end
      default: begin
        // spare opcodes leave the list alone
      end
    endcase
    r.count = list_count;
    r.empty = (list_count == 0);
    return r;
  endfunction

  function automatic void add_row(logic [bdel_pkg::OPCODE_W-1:0] op,
                                  logic [bdel_pkg::PORT_DATA_W-1:0] word,
                                  logic [bdel_pkg::POS_W-1:0] pos, bit typed = 1'b0,
                                  logic [bdel_pkg::PORT_DATA_W-1:0] d = '0,
                                  bdel_pkg::status_t st = bdel_pkg::ST_OK,
                                  logic [bdel_pkg::ENTRY_CNT_W-1:0] cnt = '0,
                                  logic emp = 1'b0);
    stim_row_t row;
    row.op            = op;
    row.word          = word;
    row.pos           = pos;
    row.typed         = typed;
    row.want.data_out = d;
    row.want.status   = st;
    row.want.count    = cnt;
    row.want.empty    = emp;
    directed_rows.push_back(row);
  endfunction

  // presents one beat and holds it until the unit takes it; the expectation is
  // queued at the accepting edge, ahead of the registered result
  task automatic send_beat(logic [bdel_pkg::OPCODE_W-1:0] op,
                           logic [bdel_pkg::PORT_DATA_W-1:0] word,
                           logic [bdel_pkg::POS_W-1:0] pos, bit typed, result_t want);
    result_t predicted;
    while (!calm && $urandom_range(0, 99) < IDLE_PCT) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid    <= 1'b1;
    in_opcode   <= op;
    in_data_in  <= word;
    in_position <= pos;
    do @(posedge clk); while (!in_ready);
    predicted = apply_list_op(op, word, pos);
    pending_results.push_back(typed ? want : predicted);
  endtask

  // sender stops and waits until the unit has drained every outstanding result
  task automatic drain_pause();
    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
  endtask

  // receiver side: random back-pressure, none during the calm stretch
  always @(posedge clk) begin
    out_ready <= calm || ($urandom_range(0, 99) >= IDLE_PCT);
  end

  // result checker: every accepted result beat against the oldest expectation
  always @(posedge clk) begin
    result_t want;
    if (rst_n && out_valid && out_ready) begin
      beats_seen++;
      if (pending_results.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected result beat %0d: data %h status %0d count %0d empty %0b",
                   beats_seen, out_data_out, out_status, out_entry_count, out_is_empty);
      end else begin
        want = pending_results.pop_front();
        if (out_data_out !== want.data_out || out_status !== want.status ||
            out_entry_count !== want.count || out_is_empty !== want.empty) begin
          mismatches++;
          if (mismatches <= 10) begin
            $display("mismatch on result beat %0d", beats_seen);
            $display("  expected data %h status %0d count %0d empty %0b",
                     want.data_out, want.status, want.count, want.empty);
            $display("  got      data %h status %0d count %0d empty %0b",
                     out_data_out, out_status, out_entry_count, out_is_empty);
          end
        end
      end
    end
  end

  // watchdog
  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles with %0d results outstanding",
               cycles, pending_results.size());
      $display("FAIL");
      $finish;
    end
  end

  initial begin
    result_t                          no_want;
    logic [bdel_pkg::OPCODE_W-1:0]    op;
    logic [bdel_pkg::PORT_DATA_W-1:0] word;
    logic [bdel_pkg::POS_W-1:0]       pos;
    int                               mode;
    int                               pick;
    no_want = '0;
    mode    = 0;

    // directed table: empty-list errors, extremes of value and position, fill to capacity,
    // pushes dropped when full, reads at both ends, pops from both ends, spare opcodes
    add_row(bdel_pkg::OP_POP_FRONT, 32'h0, 4'd0, 1'b1, 32'h0, bdel_pkg::ST_EMPTY, 5'd0, 1'b1);
    add_row(bdel_pkg::OP_POP_BACK, 32'hffff_ffff, 4'd15, 1'b1, 32'h0, bdel_pkg::ST_EMPTY,
            5'd0, 1'b1);
    add_row(bdel_pkg::OP_READ, 32'h0, 4'd0, 1'b1, 32'h0, bdel_pkg::ST_OUT_RANGE, 5'd0, 1'b1);
    add_row(OP_SPARE_7, 32'hffff_ffff, 4'd15, 1'b1, 32'h0, bdel_pkg::ST_OK, 5'd0, 1'b1);
    add_row(bdel_pkg::OP_PUSH_BACK, 32'hffff_ffff, 4'd0, 1'b1, 32'h0, bdel_pkg::ST_OK,
            5'd1, 1'b0);
    add_row(bdel_pkg::OP_PUSH_FRONT, 32'h0, 4'd15, 1'b1, 32'h0, bdel_pkg::ST_OK, 5'd2, 1'b0);
    for (int k = 0; k < CAP - 2; k++)
      add_row(k[0] ? bdel_pkg::OP_PUSH_FRONT : bdel_pkg::OP_PUSH_BACK,
              32'h5a00_0000 + k, 4'(k));
    add_row(bdel_pkg::OP_PUSH_BACK, 32'h1234_5678, 4'd0, 1'b1, 32'h0, bdel_pkg::ST_FULL,
            5'd16, 1'b0);
    add_row(bdel_pkg::OP_PUSH_FRONT, 32'h8765_4321, 4'd0, 1'b1, 32'h0, bdel_pkg::ST_FULL,
            5'd16, 1'b0);
    add_row(bdel_pkg::OP_READ, 32'h0, 4'd15);
    add_row(bdel_pkg::OP_READ, 32'h0, 4'd0);
    add_row(bdel_pkg::OP_POP_BACK, 32'h0, 4'd0);
    add_row(bdel_pkg::OP_POP_FRONT, 32'h0, 4'd0);
    add_row(bdel_pkg::OP_POP_FRONT, 32'h0, 4'd0);
    add_row(bdel_pkg::OP_READ, 32'h0, 4'd15, 1'b1, 32'h0, bdel_pkg::ST_OUT_RANGE,
            5'd13, 1'b0);
    add_row(OP_SPARE_5, 32'hdead_beef, 4'd3);
    add_row(OP_SPARE_6, 32'h0, 4'd9);

    // synchronous reset held low from time zero, released once
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (directed_rows[i])
      send_beat(directed_rows[i].op, directed_rows[i].word, directed_rows[i].pos,
                directed_rows[i].typed, directed_rows[i].want);
    drain_pause();

    // random part: blocks of 40 beats lean toward filling, draining or neither,
    // so the count sweeps from empty to full and back many times
    for (int i = 0; i < RANDOM_BEATS; i++) begin
      if (i % 40 == 0)
        mode = $urandom_range(0, 2);
      calm = (i >= 100 && i < 220);
      if (i == RANDOM_BEATS / 2)
        drain_pause();

      pick = $urandom_range(0, 99);
      if (pick < 3) begin
        op = bdel_pkg::OPCODE_W'($urandom_range(OP_SPARE_5, OP_SPARE_7));
      end else if (pick < 18) begin
        op = bdel_pkg::OP_READ;
      end else begin
        pick = $urandom_range(0, 99);
        if (pick < (mode == 0 ? 75 : mode == 1 ? 25 : 50))
          op = $urandom_range(0, 1) ? bdel_pkg::OP_PUSH_FRONT : bdel_pkg::OP_PUSH_BACK;
        else
          op = $urandom_range(0, 1) ? bdel_pkg::OP_POP_FRONT : bdel_pkg::OP_POP_BACK;
      end

      case ($urandom_range(0, 9))
        0:       word = '0;
        1:       word = '1;
        default: word = $urandom;
      endcase

      // reads mostly land inside the list, the rest anywhere
      if (op == bdel_pkg::OP_READ && list_count != 0 && $urandom_range(0, 99) < 70)
        pos = bdel_pkg::POS_W'($urandom_range(0, list_count - 1));
      else
        pos = bdel_pkg::POS_W'($urandom_range(0, 15));

      send_beat(op, word, pos, 1'b0, no_want);
    end
    calm = 1'b0;

    // all beats sent: wait for the last results plus a short tail for strays
    drain_pause();
    repeat (4) @(posedge clk);
    if (mismatches == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule

@@ sim.f @@
+incdir+sv
sv/bdel_pkg.sv
sv/bdel_cell.sv
sv/bounded_double_ended_list_unit.sv
tb/bounded_double_ended_list_unit_tb.sv
